// ----- hdl/cpsc_pkg.sv -----
`default_nettype none
package cpsc_pkg;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RESERVED = 3'd1;
    localparam logic [2:0] ST_PLUGGED  = 3'd2;
    localparam logic [2:0] ST_CHARGING = 3'd3;
    localparam logic [2:0] ST_COMPLETE = 3'd4;
    localparam logic [2:0] ST_ABORTING = 3'd5;

    localparam logic [1:0] KIND_POLL    = 2'd0;
    localparam logic [1:0] KIND_RESERVE = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_FORCE   = 2'd3;

    localparam logic [1:0] REG_CURRENT_LIMIT = 2'd0;
    localparam logic [1:0] REG_PURCHASED     = 2'd1;
    localparam logic [1:0] REG_LINE_VOLTS    = 2'd2;

    localparam int POWER_BITS  = 25;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  plugged;
        logic [15:0]           current_ma;
        logic                  measure_tick;
        logic [2:0]            forced_state;
        logic [POWER_BITS-1:0] power_mw;
    } item_t;

endpackage
`default_nettype wire

// ----- hdl/charge_port_session_controller.sv -----
// Channel   Dir  Transfer when               Payload
// s_axis    in   s_axis_tvalid & tready      poll or command item
// m_axis    out  m_axis_tvalid & tready      state, relay, energy, seconds left
// cfg       in   cfg_valid & cfg_ready       register index and data
//
// One item per cycle sustained while results are taken; an item passes stage one, then stage two.
// Stage one registers the item and the current times voltage product; stage two
// updates the session state, which is the result register itself.
// Result stalls hold the state and back-pressure stage one; cfg_ready is always high.
// Reset: idle, relay open, energy and time zero, registers at their defaults.
`default_nettype none
module charge_port_session_controller #(
    parameter int ENERGY_BITS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] plugged, [16:1] current_ma, [17] measure_tick, [20:18] forced_state
    input  wire logic [23:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] port_state, [3] relay_on, [51:4] energy_total, [68:52] seconds_left
    output logic [71:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import cpsc_pkg::*;

    logic [15:0] current_limit_reg;
    logic [15:0] purchased_reg;
    logic [8:0]  line_volts_reg;

    item_t       item_reg;
    item_t       item_next;
    logic        item_valid_reg;
    logic        out_valid_reg;
    logic        advance;

    logic [2:0]             mode_reg, mode_next;
    logic                   relay_reg, relay_next;
    logic                   pending_reg, pending_next;
    logic [ENERGY_BITS-1:0] energy_reg, energy_next;
    logic signed [16:0]     time_reg, time_next;

    logic [ENERGY_BITS:0]   energy_sum;
    logic                   consume;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !item_valid_reg || advance;
    assign consume       = item_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_limit_reg <= 16'd32000;
            purchased_reg     <= 16'd0;
            line_volts_reg    <= 9'd110;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CURRENT_LIMIT: current_limit_reg <= cfg_data;
                REG_PURCHASED:     purchased_reg     <= cfg_data;
                REG_LINE_VOLTS:    line_volts_reg    <= cfg_data[8:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        item_next.kind         = s_axis_tuser;
        item_next.plugged      = s_axis_tdata[0];
        item_next.current_ma   = s_axis_tdata[16:1];
        item_next.measure_tick = s_axis_tdata[17];
        item_next.forced_state = s_axis_tdata[20:18];
        item_next.power_mw     = POWER_BITS'(s_axis_tdata[16:1] * line_volts_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    assign energy_sum = {1'b0, energy_reg} + (ENERGY_BITS + 1)'(item_reg.power_mw);

    always_comb
    begin
        mode_next    = mode_reg;
        relay_next   = relay_reg;
        pending_next = pending_reg || (item_reg.measure_tick && relay_reg);
        energy_next  = energy_reg;
        time_next    = time_reg;
        unique case (item_reg.kind)
            KIND_RESERVE: mode_next = ST_RESERVED;
            KIND_RELEASE: mode_next = ST_IDLE;
            KIND_FORCE:
            begin
                if (item_reg.forced_state <= ST_ABORTING)
                begin
                    mode_next = item_reg.forced_state;
                end
            end
            default:
            begin
                unique case (mode_reg)
                    ST_RESERVED:
                    begin
                        if (item_reg.plugged)
                        begin
                            mode_next = ST_PLUGGED;
                        end
                    end
                    ST_PLUGGED:
                    begin
                        relay_next = 1'b1;
                        mode_next  = ST_CHARGING;
                        time_next  = signed'({1'b0, purchased_reg});
                    end
                    ST_CHARGING:
                    begin
                        if (pending_next)
                        begin
                            pending_next = 1'b0;
                            energy_next  = energy_sum[ENERGY_BITS] ? '1
                                                                   : energy_sum[ENERGY_BITS-1:0];
                            if (time_reg != -17'sd1)
                            begin
                                time_next = time_reg - 17'sd1;
                            end
                        end
                        if (time_next[16] || !item_reg.plugged
                            || (item_reg.current_ma > current_limit_reg))
                        begin
                            mode_next = ST_ABORTING;
                        end
                    end
                    ST_COMPLETE, ST_ABORTING: relay_next = 1'b0;
                    default: ;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ST_IDLE;
            relay_reg   <= 1'b0;
            pending_reg <= 1'b0;
            energy_reg  <= '0;
            time_reg    <= '0;
        end
        else if (consume)
        begin
            mode_reg    <= mode_next;
            relay_reg   <= relay_next;
            pending_reg <= pending_next;
            energy_reg  <= energy_next;
            time_reg    <= time_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, time_reg, 48'(energy_reg), relay_reg, mode_reg};

    a_time_floor: assert property (@(posedge clk) disable iff (!rst_n)
        time_reg[16] |-> (time_reg == -17'sd1))
        else $error("time left below -1");

    a_energy_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        energy_reg >= $past(energy_reg))
        else $error("energy sum decreased");

    a_relay_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(relay_reg) |-> ($past(mode_reg) == ST_PLUGGED && mode_reg == ST_CHARGING))
        else $error("relay closed outside start of charge");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(energy_reg) && $stable(mode_reg))
        else $error("state changed while result stalled");

endmodule
`default_nettype wire

// ----- bench/tb_charge_port_session_controller.sv -----
`default_nettype none
module tb_charge_port_session_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import cpsc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int NRG_BITS = 48;
    localparam longint unsigned NRG_CEIL = (64'd1 << NRG_BITS) - 64'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic        plugged;
        logic [15:0] current;
        logic        tick;
        logic [2:0]  forced;
    } poll_t;

    typedef struct packed {
        logic [16:0] left;
        logic [47:0] energy;
        logic        relay;
        logic [2:0]  mode;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = KIND_POLL;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_CURRENT_LIMIT;
    logic [15:0] cfg_data = '0;

    // port model
    logic [2:0]      mode_q = ST_IDLE;
    logic            relay_q = 1'b0;
    logic            tick_q = 1'b0;
    longint unsigned energy_q = 0;
    int              left_q = 0;
    logic [15:0]     lim_q = 16'd32000;
    logic [15:0]     buy_q = 16'd0;
    logic [8:0]      volts_q = 9'd110;

    poll_t   poll_backlog[$];
    status_t status_due[$];
    int      queued_count = 0;
    int      cfg_writes = 0;
    int      mismatch_count = 0;
    int      send_idle_pct = 17;
    int      recv_idle_pct = 17;
    logic    in_fire = 1'b0;

    charge_port_session_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] val);
        case (idx)
            REG_CURRENT_LIMIT: lim_q = val;
            REG_PURCHASED:     buy_q = val;
            REG_LINE_VOLTS:    volts_q = val[8:0];
            default: ;
        endcase
    endfunction

    function automatic status_t advance_port(input poll_t it);
        longint unsigned pwr;
        status_t st;
        if (it.tick && relay_q)
            tick_q = 1'b1;
        case (it.kind)
            KIND_RESERVE: mode_q = ST_RESERVED;
            KIND_RELEASE: mode_q = ST_IDLE;
            KIND_FORCE:
            begin
                if (it.forced <= ST_ABORTING)
                    mode_q = it.forced;
            end
            default:
            begin
                case (mode_q)
                    ST_RESERVED:
                    begin
                        if (it.plugged)
                            mode_q = ST_PLUGGED;
                    end
                    ST_PLUGGED:
                    begin
                        relay_q = 1'b1;
                        mode_q = ST_CHARGING;
                        left_q = int'(buy_q);
                    end
                    ST_CHARGING:
                    begin
                        if (tick_q)
                        begin
                            pwr = 64'(it.current) * 64'(volts_q);
                            tick_q = 1'b0;
                            if (energy_q > NRG_CEIL - pwr)
                                energy_q = NRG_CEIL;
                            else
                                energy_q = energy_q + pwr;
                            if (left_q > -1)
                                left_q = left_q - 1;
                        end
                        if (left_q < 0 || !it.plugged || it.current > lim_q)
                            mode_q = ST_ABORTING;
                    end
                    ST_COMPLETE, ST_ABORTING: relay_q = 1'b0;
                    default: ;
                endcase
            end
        endcase
        st.mode = mode_q;
        st.relay = relay_q;
        st.energy = energy_q[47:0];
        st.left = left_q[16:0];
        return st;
    endfunction

    function automatic void add_poll(input logic [1:0] k, input logic p, input logic [15:0] c,
                                     input logic t, input logic [2:0] f);
        poll_t it;
        it.kind = k;
        it.plugged = p;
        it.current = c;
        it.tick = t;
        it.forced = f;
        poll_backlog.push_back(it);
        queued_count++;
    endfunction

    // driver: advance on transfer, hold on stall
    always @(negedge clk)
    begin
        poll_t it;
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fire)
            begin
                if (poll_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    it = poll_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= it.kind;
                    s_axis_tdata <= {3'b000, it.forced, it.tick, it.current, it.plugged};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        poll_t   it;
        status_t got;
        status_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.kind = s_axis_tuser;
                it.plugged = s_axis_tdata[0];
                it.current = s_axis_tdata[16:1];
                it.tick = s_axis_tdata[17];
                it.forced = s_axis_tdata[20:18];
                status_due.push_back(advance_port(it));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[68:0];
                if (status_due.size() == 0)
                begin
                    $error("unexpected result transfer, data %h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (got.mode !== want.mode)
                    begin
                        $error("port_state expected %0d got %0d", want.mode, got.mode);
                        mismatch_count++;
                    end
                    if (got.relay !== want.relay)
                    begin
                        $error("relay_on expected %0d got %0d", want.relay, got.relay);
                        mismatch_count++;
                    end
                    if (got.energy !== want.energy)
                    begin
                        $error("energy_total expected %0d got %0d", want.energy, got.energy);
                        mismatch_count++;
                    end
                    if (got.left !== want.left)
                    begin
                        $error("seconds_left expected %0d got %0d",
                               $signed(want.left), $signed(got.left));
                        mismatch_count++;
                    end
                end
            end
        end
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        int start;
        start = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk);
        while (cfg_writes == start);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        do @(posedge clk);
        while (poll_backlog.size() != 0 || s_axis_tvalid || status_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] lim;
        logic [15:0] buy;
        logic [15:0] vlt;
        logic [15:0] amp;
        int target;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        add_poll(KIND_POLL, 1'b1, 16'hFFFF, 1'b1, 3'd7);
        add_poll(KIND_FORCE, 1'b0, 16'h0000, 1'b0, 3'd6);
        add_poll(KIND_FORCE, 1'b1, 16'hFFFF, 1'b1, 3'd7);
        add_poll(KIND_RESERVE, 1'b0, 16'h0000, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b0, 16'd100, 1'b1, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd100, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd100, 1'b1, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd32000, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd32000, 1'b1, ST_IDLE);
        add_poll(KIND_FORCE, 1'b1, 16'h0000, 1'b1, ST_CHARGING);
        add_poll(KIND_POLL, 1'b1, 16'd500, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'h0000, 1'b1, ST_IDLE);
        add_poll(KIND_FORCE, 1'b0, 16'h0000, 1'b0, ST_CHARGING);
        add_poll(KIND_POLL, 1'b1, 16'd1000, 1'b1, ST_IDLE);
        add_poll(KIND_RELEASE, 1'b0, 16'h0000, 1'b0, ST_IDLE);
        add_poll(KIND_RESERVE, 1'b0, 16'h0000, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd10, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd10, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'hFFFF, 1'b0, ST_IDLE);
        add_poll(KIND_FORCE, 1'b0, 16'h0000, 1'b0, ST_COMPLETE);
        add_poll(KIND_POLL, 1'b0, 16'h0000, 1'b0, ST_IDLE);
        add_poll(KIND_RESERVE, 1'b0, 16'h0000, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd10, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b1, 16'd10, 1'b0, ST_IDLE);
        add_poll(KIND_POLL, 1'b0, 16'd10, 1'b1, ST_IDLE);
        add_poll(KIND_RELEASE, 1'b1, 16'hFFFF, 1'b1, ST_ABORTING);
        wait_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    lim = 16'hFFFF;
                    buy = 16'd0;
                    vlt = 16'd400;
                end
                1:
                begin
                    lim = 16'd0;
                    buy = 16'hFFFF;
                    vlt = 16'd1;
                end
                2:
                begin
                    lim = 16'($urandom_range(20000, 65535));
                    buy = 16'd4;
                    vlt = 16'd0;
                end
                3:
                begin
                    lim = 16'd50000;
                    buy = 16'd20;
                    vlt = 16'hFFFF;
                end
                default:
                begin
                    lim = 16'($urandom_range(0, 65535));
                    buy = 16'($urandom_range(1, 30));
                    vlt = 16'($urandom_range(1, 400));
                end
            endcase
            write_reg(REG_CURRENT_LIMIT, lim);
            write_reg(REG_PURCHASED, buy);
            write_reg(REG_LINE_VOLTS, vlt);
            if (ph == 2)
                write_reg(REG_UNUSED, 16'($urandom));
            send_idle_pct = (ph == 5) ? 0 : 17;
            recv_idle_pct = (ph == 5) ? 0 : 17;

            target = queued_count + 225;
            while (queued_count < target)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    add_poll(2'($urandom), 1'($urandom), 16'($urandom), 1'($urandom),
                             3'($urandom));
                end
                else
                begin
                    add_poll(KIND_RESERVE, 1'($urandom), 16'($urandom), 1'($urandom),
                             3'($urandom));
                    repeat ($urandom_range(0, 2))
                        add_poll(KIND_POLL, 1'b0, 16'($urandom), 1'($urandom), 3'($urandom));
                    add_poll(KIND_POLL, 1'b1, 16'($urandom), 1'($urandom), 3'($urandom));
                    add_poll(KIND_POLL, 1'($urandom), 16'($urandom), 1'($urandom),
                             3'($urandom));
                    repeat ($urandom_range(0, 24))
                    begin
                        if ($urandom_range(0, 99) < 92)
                            amp = 16'($urandom_range(0, lim));
                        else
                            amp = 16'($urandom);
                        add_poll(KIND_POLL, ($urandom_range(0, 99) < 97), amp, 1'($urandom),
                                 3'($urandom));
                    end
                    repeat ($urandom_range(0, 2))
                        add_poll(KIND_POLL, 1'($urandom), 16'($urandom), 1'($urandom),
                                 3'($urandom));
                    add_poll(2'($urandom_range(1, 3)), 1'($urandom), 16'($urandom),
                             1'($urandom), 3'($urandom));
                end
            end
            wait_quiet();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && status_due.size() == 0)
            $display("tb_charge_port_session_controller: clean");
        else
            $display("tb_charge_port_session_controller: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_charge_port_session_controller: errors");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/cpsc_pkg.sv
hdl/charge_port_session_controller.sv
bench/tb_charge_port_session_controller.sv
